[rtl/usts_pkg.sv]
`timescale 1ns / 1ps
// Package for the unordered set table: field widths, operation and status codes,
// and the command struct that the table drives into every key cell.
// Depends on nothing.
package usts_pkg;

  localparam int FUNC_W    = 3;
  localparam int IN_KEY_W  = 16;
  localparam int SLOT_W    = 4;
  localparam int POS_OUT_W = 4;
  localparam int CNT_OUT_W = 5;
  localparam int STATUS_W  = 2;

  localparam logic [FUNC_W-1:0] OP_FIND   = 3'd0;
  localparam logic [FUNC_W-1:0] OP_INSERT = 3'd1;
  localparam logic [FUNC_W-1:0] OP_DELETE = 3'd2;
  localparam logic [FUNC_W-1:0] OP_CLEAR  = 3'd3;
  localparam logic [FUNC_W-1:0] OP_READ   = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

  // Update command broadcast along the cell row in the commit cycle.
  typedef struct packed {
    logic ins_en;  // append the probe key at position count
    logic del_en;  // close the gap at pos by moving later keys down one place
  } usts_cmd_t;

endpackage

[rtl/usts_cell.sv]
`timescale 1ns / 1ps
// One key cell of the set table row: holds one key, compares it against the
// probe, and loads either a new key or its upper neighbour's key. Uses usts_pkg.
module usts_cell #(
  parameter int KEY_WIDTH = 16,
  parameter int CNT_W     = 5,
  parameter int IDX_W     = 4,
  parameter int INDEX     = 0
) (
  input  logic                  clk,
  input  usts_pkg::usts_cmd_t   cmd,
  input  logic [CNT_W-1:0]      count,
  input  logic [IDX_W-1:0]      pos,
  input  logic [KEY_WIDTH-1:0]  probe,
  input  logic [KEY_WIDTH-1:0]  new_key,
  input  logic [KEY_WIDTH-1:0]  next_key,
  output logic [KEY_WIDTH-1:0]  key_q,
  output logic                  hit
);
  import usts_pkg::*;

  localparam logic [CNT_W-1:0] MY_CNT   = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] NEXT_CNT = CNT_W'(INDEX + 1);
  localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(INDEX);

  logic [KEY_WIDTH-1:0] key_r;
  logic [KEY_WIDTH-1:0] key_nxt;

  assign key_q = key_r;
  // Only entries below the count take part in a lookup.
  assign hit   = (MY_CNT < count) && (key_r == probe);

  always_comb begin
    key_nxt = key_r;
    if (cmd.ins_en && (count == MY_CNT)) begin
      key_nxt = new_key;
    end else if (cmd.del_en && (MY_IDX >= pos) && (NEXT_CNT < count)) begin
      key_nxt = next_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

[rtl/unordered_set_table_core.sv]
`timescale 1ns / 1ps
// Top level of the unordered set table: request sequencer, position encoder,
// result register and the row of key cells. Uses usts_pkg and usts_cell.
//
//  channel | direction | beat fields                                   | handshake
//  --------+-----------+-----------------------------------------------+-----------------
//  in_     | input     | func, key, slot                               | in_valid/in_stall
//  out_    | output    | found, match_position, entry_count,           | out_valid/out_stall
//          |           | read_key, status                              |
//
// Steps per beat: every cell compares the incoming key at the accept edge, the encode
// state turns the registered hit vector into a position, and the commit state commits
// the update to the cell row and loads the result register; only then is a new beat taken.
// Reset: synchronous, active low; clears the count, last match, sequencer and result
// valid. Keys are not cleared: cells at or above the count are never looked at.
// Stalls: a result waits in its register while a new beat is accepted; that beat then
// holds in its commit cycle until the register is free.
module unordered_set_table_core #(
  parameter int CAPACITY  = 16,
  parameter int KEY_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [usts_pkg::FUNC_W-1:0]         in_func,
  input  logic [usts_pkg::IN_KEY_W-1:0]       in_key,
  input  logic [usts_pkg::SLOT_W-1:0]         in_slot,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_found,
  output logic [usts_pkg::POS_OUT_W-1:0]      out_match_position,
  output logic [usts_pkg::CNT_OUT_W-1:0]      out_entry_count,
  output logic [usts_pkg::IN_KEY_W-1:0]       out_read_key,
  output logic [usts_pkg::STATUS_W-1:0]       out_status
);
  import usts_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // Width that holds both any slot number and any count.
  localparam int CW    = (CNT_W > SLOT_W) ? CNT_W : SLOT_W + 1;
  // Only the first sixteen cells can be named by a slot.
  localparam int RD_N  = (CAPACITY < (1 << SLOT_W)) ? CAPACITY : (1 << SLOT_W);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_ENC    = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [IDX_W-1:0]      last_r, last_nxt;
  logic [FUNC_W-1:0]     func_r;
  logic [KEY_WIDTH-1:0]  key_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [CAPACITY-1:0]   hit_r;
  logic [IDX_W-1:0]      pos_r, pos_nxt;
  logic                  found_r;

  logic                  out_valid_r, out_valid_nxt;
  logic                  res_found_r, res_found_nxt;
  logic [IDX_W-1:0]      res_pos_r;
  logic [CNT_W-1:0]      res_cnt_r;
  logic [KEY_WIDTH-1:0]  res_key_r, res_key_nxt;
  logic [STATUS_W-1:0]   res_stat_r, res_stat_nxt;

  logic                  accept;
  logic                  commit_go;
  logic                  slot_ok;
  logic [KEY_WIDTH-1:0]  probe;
  logic [KEY_WIDTH-1:0]  rd_key;
  logic [CAPACITY-1:0]   hit;
  logic [KEY_WIDTH-1:0]  cell_key [CAPACITY];
  usts_cmd_t             cmd;

  logic [KEY_WIDTH+IN_KEY_W-1:0] probe_wide;
  logic [KEY_WIDTH+IN_KEY_W-1:0] rkey_wide;
  logic [IDX_W+POS_OUT_W-1:0]    pos_wide;
  logic [CNT_W+CNT_OUT_W-1:0]    cnt_wide;

  // Take the key modulo 2^KEY_WIDTH, zero-extending when KEY_WIDTH is wider.
  assign probe_wide = {{KEY_WIDTH{1'b0}}, in_key};
  assign probe      = probe_wide[KEY_WIDTH-1:0];

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  // Commit once the result register is empty or being drained.
  assign commit_go = (state_r == S_COMMIT) && (!out_valid_r || !out_stall);

  // Row of key cells; each cell shifts in its upper neighbour's key on a delete.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [KEY_WIDTH-1:0] nb_key;
    if (g == CAPACITY - 1) begin : g_top
      assign nb_key = '0;
    end else begin : g_mid
      assign nb_key = cell_key[g+1];
    end
    usts_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .CNT_W     (CNT_W),
      .IDX_W     (IDX_W),
      .INDEX     (g)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .count    (count_r),
      .pos      (pos_r),
      .probe    (probe),
      .new_key  (key_r),
      .next_key (nb_key),
      .key_q    (cell_key[g]),
      .hit      (hit[g])
    );
  end

  // Held keys are distinct, so at most one hit: OR the indices together.
  always_comb begin
    pos_nxt = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit_r[i]) begin
        pos_nxt = pos_nxt | IDX_W'(i);
      end
    end
  end

  // Read port over the slot-addressable cells.
  assign slot_ok = CW'(slot_r) < CW'(count_r);
  always_comb begin
    rd_key = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (CW'(slot_r) == CW'(i)) begin
        rd_key = cell_key[i];
      end
    end
  end

  // Commit: decide the update and the result beat.
  always_comb begin
    cmd           = '0;
    count_nxt     = count_r;
    last_nxt      = last_r;
    res_found_nxt = 1'b0;
    res_key_nxt   = '0;
    res_stat_nxt  = STAT_OK;
    if (commit_go) begin
      case (func_r)
        OP_FIND: begin
          res_found_nxt = found_r;
          if (found_r) last_nxt = pos_r;
        end
        OP_INSERT: begin
          if (found_r) begin
            res_found_nxt = 1'b1;
            last_nxt      = pos_r;
          end else if (count_r == FULL_CNT) begin
            res_stat_nxt = STAT_FULL;
          end else begin
            cmd.ins_en = 1'b1;
            count_nxt  = count_r + 1'b1;
          end
        end
        OP_DELETE: begin
          if (found_r) begin
            res_found_nxt = 1'b1;
            last_nxt      = pos_r;
            cmd.del_en    = 1'b1;
            count_nxt     = count_r - 1'b1;
          end
        end
        OP_CLEAR: begin
          count_nxt = '0;
        end
        OP_READ: begin
          if (slot_ok) res_key_nxt  = rd_key;
          else         res_stat_nxt = STAT_RANGE;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (accept) state_nxt = S_ENC;
      S_ENC:    state_nxt = S_COMMIT;
      S_COMMIT: if (commit_go) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit_go)      out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request, hit vector, position and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      key_r  <= probe;
      slot_r <= in_slot;
      hit_r  <= hit;
    end
    if (state_r == S_ENC) begin
      pos_r   <= pos_nxt;
      found_r <= |hit_r;
    end
    if (commit_go) begin
      res_found_r <= res_found_nxt;
      res_pos_r   <= last_nxt;
      res_cnt_r   <= count_nxt;
      res_key_r   <= res_key_nxt;
      res_stat_r  <= res_stat_nxt;
    end
  end

  assign rkey_wide = {{IN_KEY_W{1'b0}}, res_key_r};
  assign pos_wide  = {{POS_OUT_W{1'b0}}, res_pos_r};
  assign cnt_wide  = {{CNT_OUT_W{1'b0}}, res_cnt_r};

  assign out_valid          = out_valid_r;
  assign out_found          = res_found_r;
  assign out_match_position = pos_wide[POS_OUT_W-1:0];
  assign out_entry_count    = cnt_wide[CNT_OUT_W-1:0];
  assign out_read_key       = rkey_wide[IN_KEY_W-1:0];
  assign out_status         = res_stat_r;

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count beyond capacity");

  // Held keys stay distinct, so no lookup hits two cells.
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENC) |-> $onehot0(hit_r))
    else $error("key held in more than one cell");

  // An accepted beat moves straight on to the encode cycle.
  a_accept_enc: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_ENC))
    else $error("accepted beat not encoded");

  // A successful delete removes exactly one entry.
  a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
    (commit_go && (func_r == OP_DELETE) && found_r)
      |=> (count_r == $past(count_r) - 1'b1))
    else $error("delete did not drop the count by one");

  // A commit always leaves a result beat waiting.
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit_go |=> out_valid)
    else $error("commit without result beat");

endmodule

[dv/unordered_set_table_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for unordered_set_table_core: a clocked driver fed from a request
// queue, a stalling receiver and a monitor that checks every result beat in order.
// Depends on usts_pkg and the core RTL.
module unordered_set_table_core_tb;
  import usts_pkg::*;

  localparam int TABLE_DEPTH    = 16;
  localparam int RANDOM_ITEMS   = 1050;
  localparam int KEY_POOL_SIZE  = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 12;

  // Highest unused operation code; every code above OP_READ does nothing.
  localparam logic [FUNC_W-1:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [IN_KEY_W-1:0] key;
    logic [SLOT_W-1:0]   slot;
  } request_t;

  typedef struct packed {
    logic                 found;
    logic [POS_OUT_W-1:0] pos;
    logic [CNT_OUT_W-1:0] count;
    logic [IN_KEY_W-1:0]  rkey;
    logic [STATUS_W-1:0]  status;
  } table_result_t;

  // Receiver behaviour, re-picked at random whenever the current mode runs out.
  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic [FUNC_W-1:0]    in_func   = '0;
  logic [IN_KEY_W-1:0]  in_key    = '0;
  logic [SLOT_W-1:0]    in_slot   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_found;
  logic [POS_OUT_W-1:0] out_match_position;
  logic [CNT_OUT_W-1:0] out_entry_count;
  logic [IN_KEY_W-1:0]  out_read_key;
  logic [STATUS_W-1:0]  out_status;

  unordered_set_table_core #(
    .CAPACITY (TABLE_DEPTH),
    .KEY_WIDTH(IN_KEY_W)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_key            (in_key),
    .in_slot           (in_slot),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_found         (out_found),
    .out_match_position(out_match_position),
    .out_entry_count   (out_entry_count),
    .out_read_key      (out_read_key),
    .out_status        (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  request_t      pending_requests[$];
  table_result_t expected_results[$];
  int            failures     = 0;
  int            results_seen = 0;
  int            quiet_cycles = 0;

  // Shadow of the table contents, updated once per accepted request beat.
  logic [IN_KEY_W-1:0]  shadow_keys [TABLE_DEPTH];
  logic [CNT_OUT_W-1:0] shadow_count = '0;
  logic [POS_OUT_W-1:0] shadow_last  = '0;

  // Apply one request to the shadow table and return the result it must produce.
  function automatic table_result_t apply_request(input logic [FUNC_W-1:0] func,
                                                  input logic [IN_KEY_W-1:0] key,
                                                  input logic [SLOT_W-1:0] slot);
    table_result_t res;
    int            hit;
    int            i;
    res = '0;
    hit = -1;
    // Only find, insert and delete search; the first match wins and moves last match.
    if (func == OP_FIND || func == OP_INSERT || func == OP_DELETE) begin
      for (i = 0; i < int'(shadow_count); i++) begin
        if (hit < 0 && shadow_keys[i] == key) hit = i;
      end
    end
    if (hit >= 0) shadow_last = POS_OUT_W'(hit);
    case (func)
      OP_FIND: begin
        res.found = (hit >= 0);
      end
      OP_INSERT: begin
        if (hit >= 0) begin
          res.found = 1'b1;
        end else if (shadow_count >= TABLE_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          shadow_keys[shadow_count] = key;
          shadow_count = shadow_count + 1'b1;
        end
      end
      OP_DELETE: begin
        if (hit >= 0) begin
          res.found = 1'b1;
          // Close the gap: every later key moves down one place.
          for (i = hit; i + 1 < int'(shadow_count); i++) shadow_keys[i] = shadow_keys[i + 1];
          shadow_count = shadow_count - 1'b1;
        end
      end
      OP_CLEAR: begin
        shadow_count = '0;
      end
      OP_READ: begin
        if (slot < shadow_count) res.rkey = shadow_keys[slot];
        else res.status = STAT_RANGE;
      end
      default: ;
    endcase
    res.pos   = shadow_last;
    res.count = shadow_count;
    return res;
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endtask

  task automatic queue_request(input logic [FUNC_W-1:0] func, input logic [IN_KEY_W-1:0] key,
                               input logic [SLOT_W-1:0] slot);
    request_t req;
    req.func = func;
    req.key  = key;
    req.slot = slot;
    pending_requests = {pending_requests, req};
  endtask

  // Sender: bursts of random length with random gaps. A beat that is stalled holds
  // its payload and its valid; the next beat is only loaded once the current one has gone.
  int burst_left = 4;
  int gap_left   = 0;

  always @(posedge clk) begin : driver
    request_t next_req;
    int       roll;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results = {expected_results, apply_request(in_func, in_key, in_slot)};
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || pending_requests.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          next_req = pending_requests.pop_front();
          in_func  <= next_req.func;
          in_key   <= next_req.key;
          in_slot  <= next_req.slot;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            roll = $urandom_range(0, 99);
            // Mostly short gaps, some back-to-back bursts, now and then a long pause.
            if (roll < 30) gap_left = 0;
            else if (roll < 85) gap_left = $urandom_range(1, 4);
            else gap_left = $urandom_range(5, 20);
          end
        end
      end
    end
  end

  // Receiver: its own stall pattern, independent of the sender.
  rx_mode_t rx_mode      = RX_OPEN;
  int       rx_mode_left = 0;
  int       rx_tick      = 0;

  always @(posedge clk) begin : receiver
    rx_tick++;
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(40, 200);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      RX_OPEN:  out_stall <= 1'b0;
      RX_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
      RX_HEAVY: out_stall <= ($urandom_range(0, 99) < 70);
      default:  out_stall <= (rx_tick % 3 == 0);
    endcase
  end

  // Monitor: check each result beat against the oldest expectation.
  always @(posedge clk) begin : monitor
    table_result_t got;
    table_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.found  = out_found;
      got.pos    = out_match_position;
      got.count  = out_entry_count;
      got.rkey   = out_read_key;
      got.status = out_status;
      if (expected_results.size() == 0) begin
        note_failure($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = expected_results.pop_front();
        if (got.found !== want.found || got.pos !== want.pos || got.count !== want.count ||
            got.rkey !== want.rkey || got.status !== want.status) begin
          note_failure($sformatf({"result %0d mismatch: expected found=%0b pos=%0d count=%0d ",
                                  "key=%h status=%0d, got found=%0b pos=%0d count=%0d ",
                                  "key=%h status=%0d"},
                                 results_seen, want.found, want.pos, want.count, want.rkey,
                                 want.status, got.found, got.pos, got.count, got.rkey,
                                 got.status));
        end
      end
      results_seen++;
    end
  end

  // Watchdog: end the run if neither channel moves a beat for too long.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [IN_KEY_W-1:0] key_pool [KEY_POOL_SIZE];
    logic [IN_KEY_W-1:0] key;
    logic [FUNC_W-1:0]   func;
    int                  bias_insert;
    int                  roll;
    int                  n;

    // Directed opening: empty table, extremes of the key, duplicate insert, delete from
    // the front, delete of an absent key, an unused code, clear, then fill to capacity.
    queue_request(OP_FIND,   16'h0000, 4'd0);
    queue_request(OP_READ,   16'h0000, 4'd0);
    queue_request(OP_INSERT, 16'h0000, 4'd0);
    queue_request(OP_INSERT, 16'hFFFF, 4'd15);
    queue_request(OP_INSERT, 16'hFFFF, 4'd0);
    queue_request(OP_FIND,   16'hFFFF, 4'd0);
    queue_request(OP_READ,   16'h0000, 4'd1);
    queue_request(OP_DELETE, 16'h0000, 4'd0);
    queue_request(OP_DELETE, 16'h1234, 4'd0);
    queue_request(OP_UNUSED, 16'hFFFF, 4'd15);
    queue_request(OP_CLEAR,  16'h0000, 4'd0);
    // The store still holds the old key after clear, but nothing may see it.
    queue_request(OP_READ,   16'h0000, 4'd0);
    queue_request(OP_FIND,   16'hFFFF, 4'd0);
    for (n = 0; n < TABLE_DEPTH; n++) queue_request(OP_INSERT, 16'h0001 << n, SLOT_W'(n));
    queue_request(OP_INSERT, 16'hA5A5, 4'd0);
    queue_request(OP_READ,   16'h0000, 4'd15);
    queue_request(OP_DELETE, 16'h0010, 4'd0);

    // Random part: a small key pool keeps hits, duplicates and a full table common,
    // while phases lean towards growing or shrinking the table, or keep it balanced.
    for (n = 0; n < KEY_POOL_SIZE; n++) key_pool[n] = IN_KEY_W'($urandom_range(0, 65535));
    bias_insert = 30;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) begin
        roll = $urandom_range(0, 2);
        bias_insert = (roll == 0) ? 45 : (roll == 1) ? 15 : 29;
      end
      if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
      else key = IN_KEY_W'($urandom_range(0, 65535));
      roll = $urandom_range(0, 99);
      if (roll < 2) func = OP_CLEAR;
      else if (roll < 4) func = FUNC_W'($urandom_range(int'(OP_READ) + 1, int'(OP_UNUSED)));
      else if (roll < 22) func = OP_READ;
      else if (roll < 42) func = OP_FIND;
      else if (roll < 42 + bias_insert) func = OP_INSERT;
      else func = OP_DELETE;
      queue_request(func, key, SLOT_W'($urandom_range(0, 15)));
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: every request sent and every result back, then let the pipeline settle.
    while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_results.size()));

    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
